FILE: src/jss_pkg.sv
// Shared types, constants and the fixed-point log function for the
// Jensen-Shannon similarity score block. No dependencies.
package jss_pkg;

    localparam int PROB_FRAC_BITS = 16;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);

    localparam logic [6:0]         LEN_RESET = 7'd5;
    localparam logic signed [21:0] LN2_Q16   = 22'sd45426;
    localparam logic signed [17:0] SCORE_ONE = 18'sd65536;

    typedef enum logic [1:0] {
        BR_MATCH   = 2'd0,
        BR_CLOSER  = 2'd1,
        BR_FARTHER = 2'd2
    } t_branch;

    // One queued element pair with its vector position flags.
    typedef struct packed {
        logic [16:0] pred;
        logic [16:0] truep;
        logic [6:0]  len;
        logic        first;
        logic        last;
    } t_item;

    function automatic logic [16:0] ln_tab(input logic [4:0] k);
        logic [16:0] v;
        unique case (k)
            5'd0:    v = 17'd0;
            5'd1:    v = 17'd3973;
            5'd2:    v = 17'd7719;
            5'd3:    v = 17'd11262;
            5'd4:    v = 17'd14624;
            5'd5:    v = 17'd17821;
            5'd6:    v = 17'd20870;
            5'd7:    v = 17'd23783;
            5'd8:    v = 17'd26573;
            5'd9:    v = 17'd29248;
            5'd10:   v = 17'd31818;
            5'd11:   v = 17'd34292;
            5'd12:   v = 17'd36675;
            5'd13:   v = 17'd38975;
            5'd14:   v = 17'd41196;
            5'd15:   v = 17'd43345;
            5'd16:   v = 17'd45426;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    // ln(x / 2^16) in Q16: exponent from leading one, mantissa by table
    // plus linear interpolation over the low 12 bits.
    function automatic logic signed [21:0] fx_ln(input logic [17:0] x);
        logic [4:0]         e;
        logic [33:0]        sh;
        logic [15:0]        g;
        logic [16:0]        t0;
        logic [16:0]        t1;
        logic [24:0]        prod;
        logic signed [21:0] base;
        e = 5'd0;
        for (int k = 0; k < 18; k++) begin
            if (x[k]) e = 5'(k);
        end
        sh   = {x, 16'b0} >> e;
        g    = sh[15:0];
        t0   = ln_tab({1'b0, g[15:12]});
        t1   = ln_tab({1'b0, g[15:12]} + 5'd1);
        prod = 25'(t1 - t0) * 25'(g[11:0]) + 25'd2048;
        base = ($signed({17'b0, e}) - 22'sd16) * LN2_Q16;
        return base + $signed({5'b0, t0}) + $signed({9'b0, prod[24:12]});
    endfunction

endpackage

FILE: src/jss_front.sv
// Front end: holds the length register, counts elements, tags each pair
// with first/last flags. Depends on jss_pkg.
module jss_front import jss_pkg::*; #(
    parameter int MAX_LENGTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [16:0] i_pred_prob,
    input  logic [16:0] i_true_prob,
    input  logic        i_q_full,
    output logic        o_push,
    output t_item       o_item
);
    logic [6:0] r_len;
    logic [6:0] r_count;
    logic [6:0] n_count;
    logic [6:0] len_eff;
    logic [7:0] cnt_inc;

    always_comb begin
        if (r_len < 7'd2)                  len_eff = 7'd2;
        else if (int'(r_len) > MAX_LENGTH) len_eff = 7'(MAX_LENGTH);
        else                               len_eff = r_len;
    end

    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;
    assign cnt_inc = {1'b0, r_count} + 8'd1;

    always_comb begin
        o_item.pred  = i_pred_prob;
        o_item.truep = i_true_prob;
        o_item.len   = len_eff;
        o_item.first = (r_count == 7'd0);
        o_item.last  = (cnt_inc >= {1'b0, len_eff});
        n_count      = o_item.last ? 7'd0 : cnt_inc[6:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= LEN_RESET;
            r_count <= 7'd0;
        end else begin
            if (i_cfg_we) r_len <= i_cfg_data;
            if (o_push)   r_count <= n_count;
        end
    end
endmodule

FILE: src/jss_queue.sv
// Short queue between the front and back ends.
// Depends on jss_pkg.
module jss_queue import jss_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_full,
    output logic  o_empty
);
    t_item                 r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]     r_wptr;
    logic [QPTR_W-1:0]     r_rptr;
    logic [QPTR_W:0]       r_fill;

    assign o_full  = (r_fill == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_fill == '0);
    assign o_item  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wptr] <= i_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) r_wptr <= r_wptr + 1'b1;
            if (i_pop)  r_rptr <= r_rptr + 1'b1;
            r_fill <= r_fill + (QPTR_W+1)'(i_push) - (QPTR_W+1)'(i_pop);
        end
    end
endmodule

FILE: src/jss_back.sv
// Back end: log-term engine, four accumulators, shared restoring divider,
// score selection and output register. Depends on jss_pkg.
module jss_back import jss_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  t_item              i_item,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [17:0] o_score,
    output logic [1:0]         o_branch
);
    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_DIV  = 10'b0000000010,
        S_LNS  = 10'b0000000100,
        S_LNA  = 10'b0000001000,
        S_LNB  = 10'b0000010000,
        S_MULB = 10'b0000100000,
        S_TERM = 10'b0001000000,
        S_ACC  = 10'b0010000000,
        S_SCOR = 10'b0100000000,
        S_OUT  = 10'b1000000000
    } t_state;

    typedef enum logic [1:0] {
        DK_UNI = 2'd0,
        DK_TP  = 2'd1,
        DK_PU  = 2'd2
    } t_divkind;

    t_state             r_state;
    t_item              r_item;
    logic [1:0]         r_pair;
    logic signed [39:0] r_acc [4];
    logic [16:0]        r_u;
    logic [6:0]         r_u_len;
    logic               r_u_ok;
    logic signed [22:0] r_lm;
    logic signed [21:0] r_la;
    logic signed [21:0] r_lb;
    logic signed [39:0] r_pa;
    logic signed [39:0] r_pb;
    logic signed [39:0] r_term;
    logic [39:0]        r_rem;
    logic [39:0]        r_den;
    logic [16:0]        r_feed;
    logic [16:0]        r_quo;
    logic [4:0]         r_dcnt;
    t_divkind           r_dkind;
    logic signed [17:0] r_res_score;
    logic [1:0]         r_res_branch;
    logic signed [17:0] r_score;
    logic [1:0]         r_branch;
    logic               r_ovalid;

    logic [16:0]        a_op;
    logic [16:0]        b_op;
    logic [16:0]        pt_op;
    logic signed [21:0] ln_out;
    logic [17:0]        ln_in;
    logic [40:0]        dv_t;
    logic               dv_ge;
    logic signed [40:0] sum_ab;
    logic signed [40:0] acc_sum;
    logic signed [39:0] acc_sat;
    logic               out_free;

    assign pt_op = r_item.first ? 17'd65536 : 17'd0;

    always_comb begin
        unique case (r_pair)
            2'd0: begin a_op = r_item.pred;  b_op = r_item.truep; end
            2'd1: begin a_op = r_item.truep; b_op = r_u;          end
            2'd2: begin a_op = r_item.pred;  b_op = r_u;          end
            default: begin a_op = r_u;       b_op = pt_op;        end
        endcase
    end

    always_comb begin
        priority case (1'b1)
            r_state == S_LNS: ln_in = {1'b0, a_op} + {1'b0, b_op};
            r_state == S_LNA: ln_in = {1'b0, a_op};
            default:          ln_in = {1'b0, b_op};
        endcase
        ln_out = fx_ln(ln_in);
    end

    assign dv_t    = {r_rem, r_feed[16]};
    assign dv_ge   = dv_t >= {1'b0, r_den};
    assign sum_ab  = 41'(r_pa) + 41'(r_pb);
    assign acc_sum = 41'(r_acc[r_pair]) + 41'(r_term);

    always_comb begin
        if (acc_sum > 41'sh7F_FFFF_FFFF)        acc_sat = 40'sh7F_FFFF_FFFF;
        else if (acc_sum < -41'sh80_0000_0000)  acc_sat = 40'sh80_0000_0000;
        else                                    acc_sat = acc_sum[39:0];
    end

    assign out_free = !r_ovalid || !i_stall;
    assign o_pop    = (r_state == S_IDLE) && !i_q_empty;
    assign o_valid  = r_ovalid;
    assign o_score  = r_score;
    assign o_branch = r_branch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pair   <= 2'd0;
            r_u_ok   <= 1'b0;
            r_ovalid <= 1'b0;
            for (int k = 0; k < 4; k++) r_acc[k] <= '0;
        end else begin
            if (r_ovalid && !i_stall && r_state != S_OUT) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (!i_q_empty) begin
                    r_item <= i_item;
                    r_pair <= 2'd0;
                    if (r_u_ok && r_u_len == i_item.len) begin
                        r_state <= S_LNS;
                    end else begin
                        r_rem   <= '0;
                        r_den   <= {33'b0, i_item.len};
                        r_feed  <= 17'd65536 + {11'b0, i_item.len[6:1]};
                        r_dcnt  <= 5'd17;
                        r_dkind <= DK_UNI;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem  <= dv_ge ? 40'(dv_t - {1'b0, r_den}) : dv_t[39:0];
                    r_feed <= {r_feed[15:0], 1'b0};
                    r_quo  <= {r_quo[15:0], dv_ge};
                    r_dcnt <= r_dcnt - 5'd1;
                    if (r_dcnt == 5'd1) begin
                        unique case (r_dkind)
                            DK_UNI: begin
                                r_u     <= {r_quo[15:0], dv_ge};
                                r_u_len <= r_item.len;
                                r_u_ok  <= 1'b1;
                                r_state <= S_LNS;
                            end
                            DK_TP: begin
                                r_res_score <= SCORE_ONE
                                             - $signed({2'b0, r_quo[14:0], dv_ge});
                                r_state <= S_OUT;
                            end
                            default: begin
                                r_res_score <= -$signed({2'b0, r_quo[14:0], dv_ge});
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_LNS: begin
                    r_lm    <= 23'(ln_out) - 23'(LN2_Q16);
                    r_state <= S_LNA;
                end
                S_LNA: begin
                    r_la    <= ln_out;
                    r_state <= S_LNB;
                end
                S_LNB: begin
                    r_pa    <= (a_op != 17'd0)
                             ? 40'($signed({1'b0, a_op})) * 40'(23'(r_la) - r_lm) : '0;
                    r_lb    <= ln_out;
                    r_state <= S_MULB;
                end
                S_MULB: begin
                    r_pb    <= (b_op != 17'd0)
                             ? 40'($signed({1'b0, b_op})) * 40'(23'(r_lb) - r_lm) : '0;
                    r_state <= S_TERM;
                end
                S_TERM: begin
                    // halve, rounding toward zero
                    r_term  <= 40'((sum_ab + 41'(sum_ab < 0)) >>> 1);
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc[r_pair] <= acc_sat;
                    r_pair        <= r_pair + 2'd1;
                    if (r_pair != 2'd3)     r_state <= S_LNS;
                    else if (r_item.last)   r_state <= S_SCOR;
                    else                    r_state <= S_IDLE;
                end
                S_SCOR: begin
                    r_dcnt <= 5'd16;
                    r_feed <= '0;
                    priority if (r_acc[0] <= 0) begin
                        r_res_score  <= SCORE_ONE;
                        r_res_branch <= BR_MATCH;
                        r_state      <= S_OUT;
                    end else if (r_acc[0] < r_acc[1]) begin
                        r_res_branch <= BR_CLOSER;
                        r_rem        <= r_acc[0];
                        r_den        <= r_acc[1];
                        r_dkind      <= DK_TP;
                        r_state      <= S_DIV;
                    end else begin
                        r_res_branch <= BR_FARTHER;
                        if (r_acc[3] <= 0 || r_acc[2] >= r_acc[3]) begin
                            r_res_score <= -SCORE_ONE;
                            r_state     <= S_OUT;
                        end else if (r_acc[2] <= 0) begin
                            r_res_score <= '0;
                            r_state     <= S_OUT;
                        end else begin
                            r_rem   <= r_acc[2];
                            r_den   <= r_acc[3];
                            r_dkind <= DK_PU;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_OUT: if (out_free) begin
                    r_ovalid <= 1'b1;
                    r_score  <= r_res_score;
                    r_branch <= r_res_branch;
                    for (int k = 0; k < 4; k++) r_acc[k] <= '0;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: src/jensen_shannon_similarity_score.sv
// Top level of the Jensen-Shannon similarity score block.
// Depends on jss_pkg, jss_front, jss_queue and jss_back.
//
// - Input channel: i_in_valid / o_in_stall carry one element pair request
//   (i_pred_prob, i_true_prob), unsigned Q1.16.
// - Output channel: o_out_valid / i_out_stall carry one score per vector:
//   o_score (signed Q1.16, -1..1) and o_branch_taken (0 match, 1 closer
//   than uniform, 2 farther than uniform).
// - i_cfg_we / i_cfg_data write the vector length N (clamped 2..MAX_LENGTH).
// - Per pair: the back end pops it, recomputes the uniform element on the
//   divider when N differs from the cached value, then computes four JS
//   terms of six steps each on one shared log unit.
// - After the last pair: S_SCOR picks the branch, the 1-bit-per-cycle
//   divider runs on the ratio branches, and S_OUT loads the output
//   register once it is free.
// - A 4-entry queue lets the front take pairs while the back is busy.
// - Reset (synchronous, active low) clears state and output valid; N = 5.
// - While i_out_stall holds, the score stays put; the back finishes its
//   current vector and holds the next score until the register frees.
module jensen_shannon_similarity_score import jss_pkg::*; #(
    parameter int MAX_LENGTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [6:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [16:0]        i_pred_prob,
    input  logic [16:0]        i_true_prob,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [17:0] o_score,
    output logic [1:0]         o_branch_taken
);
    t_item q_in;
    t_item q_out;
    logic  q_push;
    logic  q_pop;
    logic  q_full;
    logic  q_empty;

    jss_front #(.MAX_LENGTH(MAX_LENGTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_in_valid),
        .o_stall     (o_in_stall),
        .i_pred_prob (i_pred_prob),
        .i_true_prob (i_true_prob),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_item      (q_in)
    );

    jss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .i_pop   (q_pop),
        .o_item  (q_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    jss_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_item    (q_out),
        .o_pop     (q_pop),
        .o_valid   (o_out_valid),
        .i_stall   (i_out_stall),
        .o_score   (o_score),
        .o_branch  (o_branch_taken)
    );

    a_branch_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_branch_taken != 2'd3)
        else $error("invalid branch code");

    a_match_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_branch_taken == BR_MATCH |-> o_score == SCORE_ONE)
        else $error("match branch without score of one");

    a_closer_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_branch_taken == BR_CLOSER |-> !o_score[17])
        else $error("closer branch with negative score");

    a_farther_nonpos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_branch_taken == BR_FARTHER |-> o_score <= 0)
        else $error("farther branch with positive score");
endmodule
